// ----- rtl/wwm_pkg.sv -----
package wwm_pkg;

  localparam int unsigned NEEDLE_MAX   = 16;
  localparam int unsigned NEEDLE_BYTES = 16;
  localparam int unsigned NB_W         = 4;
  localparam int unsigned LEN_W        = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH   = 2'd2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef logic [NEEDLE_BYTES-1:0][7:0] needle_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic match;
    logic left_delim;
  } cell_stat_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_NUL);
  endfunction

endpackage

// ----- rtl/wwm_cell.sv -----
module wwm_cell import wwm_pkg::*; #(
  parameter int unsigned Index = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [7:0]       byte_i,
  input  needle_t          needle_i,
  input  logic [LEN_W-1:0] len_i,
  output logic [7:0]       byte_o,
  output cell_stat_t       stat_o
);

  logic [7:0]       byte_q;
  logic [7:0]       byte_d;
  logic [LEN_W-1:0] sel;
  logic             active;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  // Cell k holds the byte k+1 places back; it pairs with needle byte len-2-k.
  assign sel    = len_i - LEN_W'(Index + 2);
  assign active = LEN_W'(Index + 1) < len_i;

  assign stat_o.match      = !active || (byte_q == needle_i[sel[NB_W-1:0]]);
  assign stat_o.left_delim = (LEN_W'(Index + 1) == len_i) && is_delim(byte_q);
  assign byte_o            = byte_q;

endmodule

// ----- rtl/whole_word_matcher_core.sv -----
// Whole-word matcher: one line byte per item, one result item per line.
// Throughput is one item per cycle while the input is not stalled; the window is a chain of byte cells.
// The result is registered and appears in the cycle after the line's last item is accepted.
// Input is stalled only while an undelivered result is held and not taken.
// Reset is asynchronous, active low: empty window, no pending match, length 1.
module whole_word_matcher_core import wwm_pkg::*; #(
  parameter int unsigned NeedleMax = NEEDLE_MAX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            char_in_i,
  input  logic                  line_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  word_found_o
);

  localparam int unsigned PosW = $clog2(NeedleMax + 2);

  logic [LEN_W-1:0]          needle_length_q;
  needle_t                   needle_q;
  logic [LEN_W-1:0]          len;
  logic [PosW-1:0]           pos_q, pos_d;
  logic                      awaiting_q, awaiting_d;
  logic                      found_q, found_d;
  logic                      out_valid_q, word_found_q;
  logic                      accept, last;
  logic                      hit, left_ok, head_ok, result;
  cell_ctrl_t                ctrl;
  logic [NeedleMax-1:0][7:0] chain;
  cell_stat_t [NeedleMax-1:0] stat;
  logic [NeedleMax-1:0]      match_vec, delim_vec;
  logic [LEN_W-1:0]          head_sel;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_length_q <= LEN_W'(1);
      needle_q        <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NEEDLE_LENGTH: needle_length_q <= cfg_data_i[LEN_W-1:0];
        CFG_NEEDLE_LOW:    needle_q[7:0]   <= cfg_data_i;
        CFG_NEEDLE_HIGH:   needle_q[15:8]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    len = needle_length_q;
    if (needle_length_q == '0) begin
      len = LEN_W'(1);
    end else if (needle_length_q > LEN_W'(NeedleMax)) begin
      len = LEN_W'(NeedleMax);
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign last       = line_end_i;
  assign ctrl.shift = accept;
  assign ctrl.clear = accept && last;

  for (genvar g = 0; g < NeedleMax; g++) begin : g_cell
    wwm_cell #(
      .Index(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .byte_i  ((g == 0) ? char_in_i : chain[(g == 0) ? 0 : g - 1]),
      .needle_i(needle_q),
      .len_i   (len),
      .byte_o  (chain[g]),
      .stat_o  (stat[g])
    );
    assign match_vec[g] = stat[g].match;
    assign delim_vec[g] = stat[g].left_delim;
  end

  assign head_sel = len - LEN_W'(1);
  assign head_ok  = (char_in_i == needle_q[head_sel[NB_W-1:0]]);
  // The cleared window reads as zero bytes, which are delimiters at the line start.
  assign left_ok  = |delim_vec;
  assign hit      = (LEN_W'(pos_q) >= head_sel) && head_ok && (&match_vec);

  always_comb begin
    found_d    = found_q || (awaiting_q && is_delim(char_in_i));
    awaiting_d = hit && left_ok;
    pos_d      = (pos_q < PosW'(NeedleMax + 1)) ? pos_q + PosW'(1) : pos_q;
    result     = found_d || awaiting_d;
    if (last) begin
      found_d    = 1'b0;
      awaiting_d = 1'b0;
      pos_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      awaiting_q <= 1'b0;
      found_q    <= 1'b0;
    end else if (accept) begin
      pos_q      <= pos_d;
      awaiting_q <= awaiting_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      word_found_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_found_o = word_found_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(NeedleMax + 1))
    else $error("line position beyond saturation");

  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (pos_q == '0 && !awaiting_q && !found_q && chain == '0))
    else $error("line state not cleared after the last item");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(accept && last))
    else $error("result item without a line end");

  a_first_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (chain == '0 && !awaiting_q))
    else $error("window not empty at the line start");

endmodule

// ----- dv/whole_word_matcher_core_test.sv -----
`timescale 1ns / 100ps

module whole_word_matcher_core_test;
  import wwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 160;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [7:0]           CHAR_TAB  = 8'h09;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [7:0]            ch;
    logic [4:0]            rep;
    logic                  last;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  typed;
    logic                  want;
  } row_t;

  localparam int unsigned DIRECTED_ROWS = 22;
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_ITEM, 8'h00, 5'd1,  1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b1, 1'b1},
    '{ROW_ITEM, 8'h41, 5'd1,  1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b1, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LOW, 64'h41, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h09, 5'd1,  1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h00, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 5'd1,  1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LENGTH, 64'd31, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LOW, {64{1'b1}}, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_HIGH, {64{1'b1}}, 1'b0, 1'b0},
    '{ROW_ITEM, 8'hFF, 5'd16, 1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b1, 1'b1},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_SPARE, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LENGTH, 64'd2, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LOW, 64'h4241, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h20, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h41, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h42, 5'd1,  1'b0, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LENGTH, 64'd1, 1'b0, 1'b0},
    '{ROW_CFG,  8'h00, 5'd0,  1'b0, CFG_NEEDLE_LOW, 64'h5A, 1'b0, 1'b0},
    '{ROW_ITEM, 8'h20, 5'd1,  1'b1, CFG_NEEDLE_LENGTH, 64'd0, 1'b0, 1'b0}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            char_in_i    = '0;
  logic                  line_end_i   = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic                  word_found_o;

  whole_word_matcher_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_in_i   (char_in_i),
    .line_end_i  (line_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_found_o(word_found_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the needle registers and the line window.
  logic [4:0]            len_reg     = 5'd1;
  logic [CFG_DATA_W-1:0] needle_lo   = '0;
  logic [CFG_DATA_W-1:0] needle_hi   = '0;
  logic [7:0]            win_q [NEEDLE_MAX];
  int                    seen_cnt    = 0;
  logic                  edge_open   = 1'b0;
  logic                  line_hit    = 1'b0;

  logic                  found_q [$];
  logic [7:0]            line_q [$];
  int unsigned           mismatches  = 0;
  int unsigned           cycle_count = 0;
  int unsigned           item_count  = 0;
  int unsigned           burst_left  = 0;
  logic                  hold_req    = 1'b0;
  int unsigned           hold_left   = 0;
  int unsigned           mode_left   = 0;
  int unsigned           rx_mode     = 0;

  initial begin
    foreach (win_q[i]) win_q[i] = '0;
  end

  function automatic int eff_len();
    if (len_reg == 5'd0) return 1;
    if (len_reg > 5'(NEEDLE_MAX)) return NEEDLE_MAX;
    return int'(len_reg);
  endfunction

  function automatic logic [7:0] needle_at(input int i);
    if (i < 8) return needle_lo[8*i +: 8];
    return needle_hi[8*(i-8) +: 8];
  endfunction

  function automatic logic word_sep(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_NUL);
  endfunction

  function automatic logic [7:0] sep_byte();
    case ($urandom_range(0, 3))
      0: return CHAR_NUL;
      1: return CHAR_TAB;
      default: return CHAR_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] letter();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  task automatic match_char(input logic [7:0] c, input logic last,
                            output logic has_res, output logic res);
    int n;
    logic hit;
    logic left_ok;
    n = eff_len();
    hit = 1'b0;
    left_ok = 1'b0;
    if (edge_open && word_sep(c)) line_hit = 1'b1;
    if (seen_cnt + 1 >= n) begin
      hit = (needle_at(n - 1) == c);
      for (int i = 0; i + 1 < n; i++) begin
        if (needle_at(n - 2 - i) != win_q[i]) hit = 1'b0;
      end
      left_ok = (seen_cnt == n - 1) ? 1'b1 : word_sep(win_q[n - 1]);
    end
    edge_open = hit && left_ok;
    for (int i = NEEDLE_MAX - 1; i > 0; i--) win_q[i] = win_q[i - 1];
    win_q[0] = c;
    if (seen_cnt < NEEDLE_MAX + 1) seen_cnt++;
    has_res = last;
    res = 1'b0;
    if (last) begin
      if (edge_open) line_hit = 1'b1;
      res = line_hit;
      foreach (win_q[i]) win_q[i] = '0;
      seen_cnt = 0;
      edge_open = 1'b0;
      line_hit = 1'b0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("MISMATCH %s: expected %0d, got %0d, cycle %0d", what, want, got, cycle_count);
    mismatches++;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (found_q.size() != 0);
  endtask

  task automatic send_char(input logic [7:0] c, input logic last,
                           input logic typed, input logic want);
    logic has_res;
    logic res;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    line_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    item_count++;
    match_char(c, last, has_res, res);
    if (has_res) found_q.push_back(typed ? want : res);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_NEEDLE_LENGTH: len_reg = val[4:0];
      CFG_NEEDLE_LOW:    needle_lo = val;
      CFG_NEEDLE_HIGH:   needle_hi = val;
      default: ;
    endcase
  endtask

  task automatic random_line();
    int unsigned n_tok;
    int unsigned kind;
    int unsigned pos;
    line_q.delete();
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) line_q.push_back(sep_byte());
      n_tok = $urandom_range(1, 4);
      for (int t = 0; t < int'(n_tok); t++) begin
        kind = $urandom_range(0, 3);
        case (kind)
          0, 1: begin
            for (int i = 0; i < eff_len(); i++) line_q.push_back(needle_at(i));
            if (kind == 1) begin
              pos = line_q.size() - 1 - $urandom_range(0, eff_len() - 1);
              line_q[pos] = letter();
            end
          end
          2: repeat ($urandom_range(1, 5)) line_q.push_back(letter());
          default: repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 4) != 0) line_q.push_back(sep_byte());
      end
      if (line_q.size() > 1 && $urandom_range(0, 2) == 0) void'(line_q.pop_back());
    end
    foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1, 1'b0, 1'b0);
  endtask

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // The receiver keeps its own stall pattern and serves one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left = mode_left - 1;
      case (rx_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: out_ready_i <= cycle_count[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (found_q.size() == 0) begin
        report_mismatch("unexpected result", 1'b0, word_found_o);
      end else begin
        if (word_found_o !== found_q[0]) report_mismatch("word_found", found_q[0], word_found_o);
        void'(found_q.pop_front());
      end
    end
  end

  initial begin
    logic [4:0]            len_val;
    logic [CFG_DATA_W-1:0] lo_val;
    logic [CFG_DATA_W-1:0] hi_val;
    logic [7:0]            nb;
    int unsigned           start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);

    foreach (DIRECTED[r]) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        write_reg(DIRECTED[r].idx, DIRECTED[r].data);
      end else begin
        for (int k = 0; k < int'(DIRECTED[r].rep); k++) begin
          send_char(DIRECTED[r].ch, DIRECTED[r].last && (k == DIRECTED[r].rep - 1),
                    DIRECTED[r].typed, DIRECTED[r].want);
        end
      end
    end

    for (int ph = 0; ph < int'(PHASES); ph++) begin
      case (ph)
        0: len_val = 5'd1;
        1: len_val = 5'd16;
        2: len_val = 5'd0;
        3: len_val = 5'd31;
        4: len_val = 5'd17;
        default: len_val = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                       : 5'($urandom_range(1, 6));
      endcase
      for (int i = 0; i < 8; i++) begin
        nb = (ph == 2) ? CHAR_NUL : letter();
        lo_val[8*i +: 8] = nb;
        nb = (ph == 2) ? CHAR_NUL : letter();
        hi_val[8*i +: 8] = nb;
      end
      write_reg(CFG_NEEDLE_LOW, lo_val);
      write_reg(CFG_NEEDLE_HIGH, hi_val);
      write_reg(CFG_NEEDLE_LENGTH, {59'd0, len_val});
      if (ph == 4) hold_req = 1'b1;
      start = item_count;
      while (item_count - start < PHASE_ITEMS) begin
        random_line();
        if (ph == 6 && item_count - start >= PHASE_ITEMS / 2 && found_q.size() != 0) begin
          in_valid_i <= 1'b0;
          wait_drained();
        end
      end
    end

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (SETTLE * 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
